// File: rtl/box_mean_filter_2d_defines.svh
// Assertion macros for the box mean filter.
// Taken in by the top level; no other dependencies.
`ifndef BOX_MEAN_FILTER_2D_DEFINES_SVH
`define BOX_MEAN_FILTER_2D_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BMF_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("bmf assertion failed");
`define BMF_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("bmf assertion failed");
`else
`define BMF_ASSERT_IMP(lbl, a, c)
`define BMF_ASSERT_NXT(lbl, a, c)
`endif
`endif

// File: rtl/bmf_pkg.sv
// Shared types and constants of the box mean filter.
// No dependencies.
`timescale 1ns / 1ps
package bmf_pkg;
    localparam int SAMPLE_W     = 16;
    localparam int ROW_W        = 13;
    localparam int CFG_W_W      = 11;
    localparam int CFG_H_W      = 13;
    localparam int CFG_R_W      = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int HEIGHT_LIMIT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic start;
        logic setup_step;
        logic read_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic setup_done;
        logic read_last;
        logic div_done;
        logic out_busy;
    } t_sts;
endpackage

// File: rtl/bmf_ifs.sv
// Channel interfaces of the box mean filter: pixel in, result out, config.
// Depends on bmf_pkg.
`timescale 1ns / 1ps
interface bmf_pix_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [bmf_pkg::SAMPLE_W-1:0]  sample;
    modport source (output valid, req_type, sample, input ready);
    modport sink   (input valid, req_type, sample, output ready);
endinterface

interface bmf_res_if;
    logic                          valid;
    logic                          ready;
    logic [bmf_pkg::SAMPLE_W-1:0]  smoothed;
    logic                          last;
    modport source (output valid, smoothed, last, input ready);
    modport sink   (input valid, smoothed, last, output ready);
endinterface

interface bmf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmf_pkg::CFG_IDX_W-1:0]   index;
    logic [bmf_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bmf_ctrl.sv
// Sequencer of the box mean filter: accept, address setup, window read,
// divide and result hand-off. Depends on bmf_pkg.
`timescale 1ns / 1ps
module bmf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pix_valid,
    input  bmf_pkg::t_sts i_sts,
    output bmf_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DLOAD = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_pix_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emit) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                if (i_sts.setup_done) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.setup_step = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.read_step = 1'b1;
                if (i_sts.read_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last read beat lands in the accumulator here
            S_DRAIN: n_state = S_DLOAD;
            S_DLOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: rtl/bmf_datapath.sv
// Datapath of the box mean filter: config registers, position counters,
// line store, window accumulator, divider and output register. Depends on bmf_pkg.
`timescale 1ns / 1ps
module bmf_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmf_pix_if.sink       i_pix,
    bmf_res_if.source     o_res,
    bmf_cfg_if.sink       i_cfg,
    input  bmf_pkg::t_cmd i_cmd,
    output bmf_pkg::t_sts o_sts
);
    localparam int DEPTH   = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_RADIUS + 1);
    localparam int LAG_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
    localparam int GW      = $clog2(LAG_MAX + 1);
    localparam int NMAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int NW      = $clog2(NMAX + 1);
    localparam int SW      = bmf_pkg::SAMPLE_W + NW;
    localparam int DW      = $clog2(SW + 1);
    localparam int ROW_W   = bmf_pkg::ROW_W;

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a,
                                               input logic [AW-1:0] d);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, d};
        if (s >= (AW + 1)'(DEPTH)) s = s - (AW + 1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] sub_wrap(input logic [AW-1:0] a,
                                               input logic [AW-1:0] d);
        logic [AW:0] s;
        if (a >= d) s = {1'b0, a} - {1'b0, d};
        else s = {1'b0, a} + (AW + 1)'(DEPTH) - {1'b0, d};
        return s[AW-1:0];
    endfunction

    // config
    logic [bmf_pkg::CFG_W_W-1:0] r_cfg_w;
    logic [bmf_pkg::CFG_H_W-1:0] r_cfg_h;
    logic [bmf_pkg::CFG_R_W-1:0] r_cfg_r;
    logic                        cfg_wr;
    logic [WW-1:0]               w_eff;
    logic [ROW_W-1:0]            h_eff;
    logic [RW-1:0]               r_eff;
    logic [GW-1:0]               lag;

    // positions
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [COL_W-1:0] r_in_col, r_out_col;
    logic [AW-1:0]    r_wr_addr, r_out_addr;
    logic [GW-1:0]    r_gap;

    // window walk
    logic [ROW_W-1:0] y0, y1, r_ry;
    logic [COL_W-1:0] x0, x1, r_rx;
    logic [RW-1:0]    back, off, r_back;
    logic [AW-1:0]    r_row_addr, r_rd_addr;
    logic [ROW_W:0]   y_hi;
    logic [WW:0]      x_hi;

    logic [bmf_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [bmf_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                         r_rd_valid;
    logic [SW-1:0]                r_sum, r_dq;
    logic [NW-1:0]                r_cnt, r_rem;
    logic [NW:0]                  rem_sh;
    logic [DW-1:0]                r_div_n;

    logic                         r_o_valid, r_o_last;
    logic [bmf_pkg::SAMPLE_W-1:0] r_o_smoothed;
    logic                         is_last, in_col_wrap, out_col_wrap;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = i_cmd.in_ready;
    assign cfg_wr      = i_cfg.valid && (i_cfg.index == bmf_pkg::REG_FRAME_WIDTH ||
                         i_cfg.index == bmf_pkg::REG_FRAME_HEIGHT ||
                         i_cfg.index == bmf_pkg::REG_RADIUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bmf_pkg::CFG_W_W'(256);
            r_cfg_h <= bmf_pkg::CFG_H_W'(256);
            r_cfg_r <= bmf_pkg::CFG_R_W'(3);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bmf_pkg::REG_FRAME_WIDTH:  r_cfg_w <= i_cfg.data[bmf_pkg::CFG_W_W-1:0];
                bmf_pkg::REG_FRAME_HEIGHT: r_cfg_h <= i_cfg.data[bmf_pkg::CFG_H_W-1:0];
                bmf_pkg::REG_RADIUS:       r_cfg_r <= i_cfg.data[bmf_pkg::CFG_R_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) w_eff = WW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(r_cfg_w);
        if (r_cfg_h == '0) h_eff = ROW_W'(1);
        else if (32'(r_cfg_h) > bmf_pkg::HEIGHT_LIMIT) h_eff = ROW_W'(bmf_pkg::HEIGHT_LIMIT);
        else h_eff = ROW_W'(r_cfg_h);
        if (32'(r_cfg_r) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
        else r_eff = RW'(r_cfg_r);
        lag = GW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
    end

    // clipped window of the current output pixel
    always_comb begin
        y0   = (r_out_row < ROW_W'(r_eff)) ? '0 : r_out_row - ROW_W'(r_eff);
        y_hi = {1'b0, r_out_row} + (ROW_W + 1)'(r_eff);
        y1   = (y_hi > {1'b0, h_eff - 1'b1}) ? h_eff - 1'b1 : y_hi[ROW_W-1:0];
        x0   = ((WW + 1)'(r_out_col) < (WW + 1)'(r_eff)) ? '0 : r_out_col - COL_W'(r_eff);
        x_hi = (WW + 1)'(r_out_col) + (WW + 1)'(r_eff);
        x1   = (x_hi > (WW + 1)'(w_eff - 1'b1)) ? COL_W'(w_eff - 1'b1) : x_hi[COL_W-1:0];
        back = RW'(r_out_row - y0);
        off  = RW'(r_out_col - x0);
    end

    assign in_col_wrap  = ((WW + 1)'(r_in_col) + 1'b1) >= (WW + 1)'(w_eff);
    assign out_col_wrap = ((WW + 1)'(r_out_col) + 1'b1) >= (WW + 1)'(w_eff);
    assign is_last      = (r_out_row == h_eff - 1'b1) &&
                          ((WW + 1)'(r_out_col) == (WW + 1)'(w_eff - 1'b1));

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr || (i_cmd.load_out && is_last)) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_wr_addr  <= '0;
            r_out_addr <= '0;
            r_gap      <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_wr_addr <= add_wrap(r_wr_addr, AW'(1));
                if (in_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
                if (r_gap != lag) r_gap <= r_gap + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_addr <= add_wrap(r_out_addr, AW'(1));
                if (out_col_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (r_in_row < h_eff)) begin
            mem[r_wr_addr] <= i_pix.req_type ? '0 : i_pix.sample;
        end
        r_rd_data <= mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.read_step;
        end
    end

    // window walk: step back to the top row, then one pixel a beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ry       <= y0;
            r_rx       <= x0;
            r_back     <= back;
            r_row_addr <= sub_wrap(r_out_addr, AW'(off));
            r_rd_addr  <= sub_wrap(r_out_addr, AW'(off));
        end else if (i_cmd.setup_step) begin
            r_back     <= r_back - 1'b1;
            r_row_addr <= sub_wrap(r_row_addr, AW'(w_eff));
            r_rd_addr  <= sub_wrap(r_row_addr, AW'(w_eff));
        end else if (i_cmd.read_step) begin
            if (r_rx == x1) begin
                r_rx       <= x0;
                r_ry       <= r_ry + 1'b1;
                r_row_addr <= add_wrap(r_row_addr, AW'(w_eff));
                r_rd_addr  <= add_wrap(r_row_addr, AW'(w_eff));
            end else begin
                r_rx      <= r_rx + 1'b1;
                r_rd_addr <= add_wrap(r_rd_addr, AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (r_rd_valid) begin
            r_sum <= r_sum + SW'(r_rd_data);
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // restoring divider, one quotient bit a cycle
    assign rem_sh = {r_rem, r_dq[SW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_n <= '0;
        end else if (i_cmd.div_start) begin
            r_div_n <= DW'(SW);
        end else if (i_cmd.div_step) begin
            r_div_n <= r_div_n - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq  <= r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_cnt}) begin
                r_rem <= NW'(rem_sh - {1'b0, r_cnt});
                r_dq  <= {r_dq[SW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[NW-1:0];
                r_dq  <= {r_dq[SW-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_smoothed <= r_dq[bmf_pkg::SAMPLE_W-1:0];
            r_o_last     <= is_last;
        end
    end

    assign o_res.valid    = r_o_valid;
    assign o_res.smoothed = r_o_smoothed;
    assign o_res.last     = r_o_last;

    always_comb begin
        o_sts            = '0;
        o_sts.emit       = (r_gap == lag);
        o_sts.setup_done = (r_back == '0);
        o_sts.read_last  = (r_rx == x1) && (r_ry == y1);
        o_sts.div_done   = (r_div_n == '0);
        o_sts.out_busy   = r_o_valid && !o_res.ready;
    end
endmodule

// File: rtl/box_mean_filter_2d.sv
// Box mean filter, top level: controller plus datapath.
// Depends on bmf_pkg, bmf_ifs, bmf_ctrl, bmf_datapath and the defines header.
//
// Usage: pixels arrive in raster order on i_pix (req_type 0 = sample,
// 1 = flush). For each pixel a window mean comes out on o_res, lagging the
// input by R*W+R beats; after a frame the host sends R*W+R flush beats, and
// o_res.last marks the final pixel. Registers on i_cfg (0 width, 1 height,
// 2 radius) must be written only while idle (the block does not enforce
// this); any write restarts the frame. A beat yielding no result is just stored;
// one yielding a result runs setup (back over the rows above the pixel in the
// window, up to R), a read of each clipped-window pixel (up to (2R+1)^2),
// a drain, a divider load, a bit-serial divide of 22 quotient bits and the
// output load, as set by the line store's single read port and the bit-serial
// divider. The result sits in an output register; a new pixel is taken while it
// waits, and the next result holds until the receiver takes it.
// Reset (synchronous, active low) restores width 256, height 256, radius 3
// and clears the frame position; the line store is not cleared.
`timescale 1ns / 1ps
`include "box_mean_filter_2d_defines.svh"
module box_mean_filter_2d #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmf_pix_if.sink   i_pix,
    bmf_res_if.source o_res,
    bmf_cfg_if.sink   i_cfg
);
    bmf_pkg::t_cmd w_cmd;
    bmf_pkg::t_sts w_sts;

    bmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bmf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

    `BMF_ASSERT_IMP(a_start_on_beat, w_cmd.start, i_pix.valid && i_pix.ready)
    `BMF_ASSERT_IMP(a_load_when_free, w_cmd.load_out, !w_sts.out_busy)
    `BMF_ASSERT_NXT(a_busy_after_emit, i_pix.valid && i_pix.ready && w_sts.emit, !i_pix.ready)
endmodule
